// ----- hw/rtl/context_symbol_histogram_core_defines.svh -----
// Assertion macros for the context symbol histogram core
`ifndef CONTEXT_SYMBOL_HISTOGRAM_CORE_DEFINES_SVH
`define CONTEXT_SYMBOL_HISTOGRAM_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CSH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CSH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSH_ASSERT(lbl, prop, msg)
`define CSH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/csh_pkg.sv -----
// Shared types, constants and helpers of the context symbol histogram core
package csh_pkg;

	localparam int QV_SYMS    = 64;
	localparam int MAX_COLS   = 128;
	localparam int COUNT_BITS = 32;

	localparam int HIST_BINS  = 256;
	localparam int CTX_COUNT  = 1 + QV_SYMS * (MAX_COLS - 1);
	localparam int CELL_COUNT = CTX_COUNT * QV_SYMS;

	localparam int HIST_W = $clog2(HIST_BINS);
	localparam int CTX_W  = $clog2(CTX_COUNT);
	localparam int CELL_W = $clog2(CELL_COUNT);
	localparam int SYM_W  = $clog2(QV_SYMS);
	localparam int SUM_W  = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef logic [COUNT_BITS-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_ADD   = 2'd2;

	localparam logic [1:0] TBL_BASE = 2'd0;
	localparam logic [1:0] TBL_QUAL = 2'd1;
	localparam logic [1:0] TBL_CNT  = 2'd2;
	localparam logic [1:0] TBL_TOT  = 2'd3;

	localparam logic [1:0] FLAG_OK    = 2'd0;
	localparam logic [1:0] FLAG_RANGE = 2'd1;
	localparam logic [1:0] FLAG_SAT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_QUALITY_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 1'b1;

	localparam logic [CFG_DATA_W-1:0] QOFF_RESET = 8'd0;
	localparam logic [CFG_DATA_W-1:0] COLS_RESET = 8'd128;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  column;
		logic [7:0]  base;
		logic [7:0]  quality;
		logic        has_quality;
		logic [1:0]  table_select;
		logic [18:0] entry_index;
		logic [31:0] add_value;
		logic        clear_after_read;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  flag;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} csh_state_t;

	typedef struct packed {
		logic clear_step;
		logic load_item;
		logic commit;
	} csh_cmd_t;

	typedef struct packed {
		logic clear_last;
	} csh_stat_t;

	function automatic logic [31:0] csh_clamp_read(count_t v);
		logic [63:0] wide;
		wide = 64'(v);
		if (wide > 64'h0000_0000_FFFF_FFFF)
			return 32'hFFFF_FFFF;
		return wide[31:0];
	endfunction

endpackage

// ----- hw/rtl/csh_item_if.sv -----
// Input channel: one symbol or table access per transaction
interface csh_item_if import csh_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ----- hw/rtl/csh_result_if.sv -----
// Output channel: one result per transaction
interface csh_result_if import csh_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

// ----- hw/rtl/csh_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module csh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/csh_ctrl.sv -----
// Sequencing state machine: clearing pass, lookup, update and result hand-off
`include "context_symbol_histogram_core_defines.svh"
module csh_ctrl import csh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  csh_stat_t stat,
	output csh_cmd_t  cmd
);
	csh_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid)
					state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.load_item = req_valid;
			end
			ST_LOOKUP: begin
			end
			ST_UPDATE: begin
				cmd.commit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	`CSH_ASSERT(a_accept_then_lookup, (req_valid && req_ready) |=> (state_q == ST_LOOKUP), "accepted transaction did not start a lookup")
	`CSH_ASSERT(a_stall_holds_update, (state_q == ST_UPDATE && out_valid_q && !rsp_ready) |=> (state_q == ST_UPDATE), "update left while result register was full")
	`CSH_ASSERT(a_result_from_update, $rose(out_valid_q) |-> $past(state_q == ST_UPDATE), "result raised outside an update")
	`CSH_ASSERT_ALWAYS(a_clear_quiet, (state_q == ST_CLEAR) |-> (!out_valid_q && !req_ready), "traffic during clearing pass")
endmodule

// ----- hw/rtl/csh_datapath.sv -----
// Datapath: item register, address forming, counter RAMs, saturating update
module csh_datapath import csh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csh_cmd_t              cmd,
	output csh_stat_t             stat,
	input  item_t                 item_in,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	item_t                 item_q;
	result_t               res_q;
	logic [SYM_W-1:0]      prev_q;
	logic [CFG_DATA_W-1:0] qoff_q;
	logic [CFG_DATA_W-1:0] cols_q;
	logic [CELL_W-1:0]     sweep_q;

	logic              is_count;
	logic              col_ok;
	logic [8:0]        qdiff;
	logic              q_ok;
	logic [SYM_W-1:0]  sym;
	logic [6:0]        col_m1;
	logic [CTX_W-1:0]  ctx;
	logic [CELL_W-1:0] cell_addr;

	logic [HIST_W-1:0] base_ra, qual_ra, base_wa, qual_wa;
	logic [CELL_W-1:0] cnt_ra, cnt_wa;
	logic [CTX_W-1:0]  tot_ra, tot_wa;
	count_t            base_rd, qual_rd, cnt_rd, tot_rd;
	count_t            base_wd, qual_wd, cnt_wd, tot_wd;
	logic              base_we, qual_we, cnt_we, tot_we;

	logic   base_full, qual_full, cnt_full, tot_full;
	count_t base_bump, qual_bump, cnt_bump, tot_bump;

	count_t           sel_rd;
	logic [31:0]      sel_depth;
	logic             idx_ok;
	logic [SUM_W-1:0] add_sum;
	logic             add_over;
	count_t           acc_wd;
	logic             acc_wr;

	logic        base_wr, qual_wr, cnt_wr, tot_wr, prev_wr;
	count_t      base_nd, qual_nd, cnt_nd, tot_nd;
	logic [31:0] data_d;
	logic        range_err, sat;
	logic [1:0]  flag_d;

	// symbol and context addressing
	assign is_count  = item_q.op == OP_COUNT;
	assign col_ok    = ({1'b0, item_q.column} < cols_q) && (32'(item_q.column) < MAX_COLS);
	assign qdiff     = {1'b0, item_q.quality} - {1'b0, qoff_q};
	assign q_ok      = !qdiff[8] && (32'(qdiff[7:0]) < QV_SYMS);
	assign sym       = qdiff[SYM_W-1:0];
	assign col_m1    = item_q.column - 7'd1;
	assign ctx       = (item_q.column == 7'd0) ? '0 :
		CTX_W'(32'd1 + 32'(col_m1) * QV_SYMS + 32'(prev_q));
	assign cell_addr = CELL_W'(32'(ctx) * QV_SYMS + 32'(sym));

	assign base_ra = is_count ? item_q.base : HIST_W'(item_q.entry_index);
	assign qual_ra = is_count ? item_q.quality : HIST_W'(item_q.entry_index);
	assign cnt_ra  = is_count ? cell_addr : CELL_W'(item_q.entry_index);
	assign tot_ra  = is_count ? ctx : CTX_W'(item_q.entry_index);

	// saturating increments
	assign base_full = base_rd == COUNT_MAX;
	assign qual_full = qual_rd == COUNT_MAX;
	assign cnt_full  = cnt_rd == COUNT_MAX;
	assign tot_full  = tot_rd == COUNT_MAX;
	assign base_bump = base_full ? base_rd : base_rd + COUNT_BITS'(1);
	assign qual_bump = qual_full ? qual_rd : qual_rd + COUNT_BITS'(1);
	assign cnt_bump  = cnt_full ? cnt_rd : cnt_rd + COUNT_BITS'(1);
	assign tot_bump  = tot_full ? tot_rd : tot_rd + COUNT_BITS'(1);

	always_comb begin
		unique case (item_q.table_select)
			TBL_BASE: begin
				sel_depth = 32'(HIST_BINS);
				sel_rd    = base_rd;
			end
			TBL_QUAL: begin
				sel_depth = 32'(HIST_BINS);
				sel_rd    = qual_rd;
			end
			TBL_CNT: begin
				sel_depth = 32'(CELL_COUNT);
				sel_rd    = cnt_rd;
			end
			TBL_TOT: begin
				sel_depth = 32'(CTX_COUNT);
				sel_rd    = tot_rd;
			end
			default: begin
				sel_depth = '0;
				sel_rd    = '0;
			end
		endcase
	end

	assign idx_ok   = 32'(item_q.entry_index) < sel_depth;
	assign add_sum  = SUM_W'(sel_rd) + SUM_W'(item_q.add_value);
	assign add_over = add_sum > SUM_W'(COUNT_MAX);
	assign acc_wr   = (item_q.op == OP_ADD) || item_q.clear_after_read;
	assign acc_wd   = (item_q.op != OP_ADD) ? '0 :
		(add_over ? COUNT_MAX : add_sum[COUNT_BITS-1:0]);

	always_comb begin
		base_wr   = 1'b0;
		qual_wr   = 1'b0;
		cnt_wr    = 1'b0;
		tot_wr    = 1'b0;
		prev_wr   = 1'b0;
		base_nd   = base_bump;
		qual_nd   = qual_bump;
		cnt_nd    = cnt_bump;
		tot_nd    = tot_bump;
		data_d    = '0;
		range_err = 1'b0;
		sat       = 1'b0;
		unique case (item_q.op)
			OP_COUNT: begin
				if (!col_ok) begin
					range_err = 1'b1;
				end else begin
					base_wr = 1'b1;
					sat     = base_full;
					if (item_q.has_quality) begin
						qual_wr = 1'b1;
						sat     = sat | qual_full;
						if (!q_ok) begin
							range_err = 1'b1;
						end else begin
							cnt_wr  = 1'b1;
							tot_wr  = 1'b1;
							prev_wr = 1'b1;
							sat     = sat | cnt_full | tot_full;
						end
					end
				end
			end
			OP_READ, OP_ADD: begin
				if (!idx_ok) begin
					range_err = 1'b1;
				end else begin
					if (item_q.op == OP_READ)
						data_d = csh_clamp_read(sel_rd);
					else
						sat = add_over;
					unique case (item_q.table_select)
						TBL_BASE: begin
							base_wr = acc_wr;
							base_nd = acc_wd;
						end
						TBL_QUAL: begin
							qual_wr = acc_wr;
							qual_nd = acc_wd;
						end
						TBL_CNT: begin
							cnt_wr = acc_wr;
							cnt_nd = acc_wd;
						end
						TBL_TOT: begin
							tot_wr = acc_wr;
							tot_nd = acc_wd;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				range_err = 1'b1;
			end
		endcase
		if (range_err)
			flag_d = FLAG_RANGE;
		else if (sat)
			flag_d = FLAG_SAT;
		else
			flag_d = FLAG_OK;
	end

	// RAM write side: clearing pass or commit
	assign base_we = cmd.clear_step ? (32'(sweep_q) < HIST_BINS) : (cmd.commit && base_wr);
	assign qual_we = cmd.clear_step ? (32'(sweep_q) < HIST_BINS) : (cmd.commit && qual_wr);
	assign cnt_we  = cmd.clear_step ? (32'(sweep_q) < CELL_COUNT) : (cmd.commit && cnt_wr);
	assign tot_we  = cmd.clear_step ? (32'(sweep_q) < CTX_COUNT) : (cmd.commit && tot_wr);
	assign base_wa = cmd.clear_step ? HIST_W'(sweep_q) : base_ra;
	assign qual_wa = cmd.clear_step ? HIST_W'(sweep_q) : qual_ra;
	assign cnt_wa  = cmd.clear_step ? sweep_q : cnt_ra;
	assign tot_wa  = cmd.clear_step ? CTX_W'(sweep_q) : tot_ra;
	assign base_wd = cmd.clear_step ? '0 : base_nd;
	assign qual_wd = cmd.clear_step ? '0 : qual_nd;
	assign cnt_wd  = cmd.clear_step ? '0 : cnt_nd;
	assign tot_wd  = cmd.clear_step ? '0 : tot_nd;

	csh_ram #(.WIDTH(COUNT_BITS), .DEPTH(HIST_BINS)) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (base_wa),
		.wdata (base_wd),
		.raddr (base_ra),
		.rdata (base_rd)
	);

	csh_ram #(.WIDTH(COUNT_BITS), .DEPTH(HIST_BINS)) u_qual_ram (
		.clk   (clk),
		.we    (qual_we),
		.waddr (qual_wa),
		.wdata (qual_wd),
		.raddr (qual_ra),
		.rdata (qual_rd)
	);

	csh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELL_COUNT)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_wa),
		.wdata (cnt_wd),
		.raddr (cnt_ra),
		.rdata (cnt_rd)
	);

	csh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CTX_COUNT)) u_tot_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (tot_wa),
		.wdata (tot_wd),
		.raddr (tot_ra),
		.rdata (tot_rd)
	);

	assign stat.clear_last = sweep_q == CELL_W'(CELL_COUNT - 1);
	assign result          = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= item_in;
		if (cmd.commit)
			res_q <= '{read_data: data_d, flag: flag_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			qoff_q  <= QOFF_RESET;
			cols_q  <= COLS_RESET;
			sweep_q <= '0;
		end else begin
			if (cmd.commit && prev_wr)
				prev_q <= sym;
			if (cmd.clear_step && !stat.clear_last)
				sweep_q <= sweep_q + CELL_W'(1);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_QUALITY_OFFSET: qoff_q <= cfg_data;
					REG_COLUMNS_IN_USE: cols_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end
endmodule

// ----- hw/rtl/context_symbol_histogram_core.sv -----
// Top level of the context symbol histogram core
// After reset the core runs a clearing pass that zeroes all four counter stores (one
// entry of each RAM per cycle); req.ready stays low until it ends, while configuration
// writes are taken throughout. Afterwards one transaction is processed at a time: accept
// in the idle state, a lookup state for the registered read of the counter RAMs, then an
// update state that updates the counters and loads the result register. The result
// register lets the next transaction be accepted while a result waits; the update
// stalls only when that register is still full. Write configuration only while no
// transaction is outstanding.
module context_symbol_histogram_core import csh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	csh_item_if.sink              req,
	csh_result_if.source          rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	csh_cmd_t  cmd;
	csh_stat_t stat;

	csh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	csh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item_in   (req.item),
		.result    (rsp.result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule
